// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/dssm_pkg.sv =====
// ----------------------------------------------------------------------------
// dssm_pkg
// Types and constants shared by the dual stack shared memory block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dssm_pkg;

   localparam int DATA_W        = 32;
   localparam int CAP_W         = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CAP_W-1:0] CAP_MIN   = 5'd2;
   localparam logic [CAP_W-1:0] CAP_TOP   = 5'd31;

   localparam logic [DATA_W-1:0] POP_UNDERFLOW = 32'hFFFF_FFFF;

   // operation codes
   localparam logic [1:0] FUNC_PUSH       = 2'd0;
   localparam logic [1:0] FUNC_POP_FIRST  = 2'd1;
   localparam logic [1:0] FUNC_POP_SECOND = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [DATA_W-1:0] value_first;
      logic signed [DATA_W-1:0] value_second;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_data;
      logic                     overflow_first;
      logic                     overflow_second;
      logic                     underflow;
      logic                     first_empty;
      logic                     second_empty;
      logic                     is_full;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // step one of a new item
      logic finish;   // step two, result is registered
      logic cfg_wr;   // capacity write, empties both stacks
   } cmd_type;

endpackage

// ===== rtl/dssm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dssm_ctrl
// Two-step sequencer: accept an item, finish it, then strobe the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dssm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              csr_valid,
   output logic              csr_ready,
   output dssm_pkg::cmd_type cmd,
   output logic              rsp_strobe
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FIN  = 1'b1;

   logic state_ff;
   logic state_in;
   logic strobe_ff;

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_FIN : ST_IDLE;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff == ST_FIN);
   assign csr_ready  = !busy;
   assign cmd.accept = start && !busy;
   assign cmd.finish = (state_ff == ST_FIN);
   assign cmd.cfg_wr = csr_valid && csr_ready;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/dssm_datapath.sv =====
// ----------------------------------------------------------------------------
// dssm_datapath
// Slot memory, stack counts, capacity register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dssm_datapath #(
   parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dssm_pkg::cmd_type               cmd,
   input  dssm_pkg::req_type               req_data,
   input  logic [dssm_pkg::CAP_W-1:0]      csr_data,
   output dssm_pkg::rsp_type               rsp_data
);

   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = dssm_pkg::CAP_W;
   localparam int IW      = (AW > CW) ? AW : CW;
   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [CW-1:0] CAP_MAX_C = CW'(CAP_MAX);

   logic [dssm_pkg::DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] second_ff, second_in;
   logic [1:0]    op_ff;
   logic [dssm_pkg::DATA_W-1:0] vs_ff;
   logic          ovf1_ff, ovf1_in;
   logic          udf_ff, udf_in;
   logic [dssm_pkg::DATA_W-1:0] rd_ff;
   dssm_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] cap;
   logic [CW:0]   used;
   logic          full_now;
   logic [CW:0]   used_next;
   logic          mem_we, mem_re;
   logic [CW-1:0] widx, ridx;
   logic [IW-1:0] widx_ext, ridx_ext;
   logic [AW-1:0] waddr, raddr;
   logic [dssm_pkg::DATA_W-1:0] wdata;
   logic          is_pop;

   // clamp the capacity into the usable range
   always_comb begin
      priority if (cap_ff < dssm_pkg::CAP_MIN) begin
         cap = dssm_pkg::CAP_MIN;
      end else if (cap_ff > CAP_MAX_C) begin
         cap = CAP_MAX_C;
      end else begin
         cap = cap_ff;
      end
   end

   assign used     = {1'b0, first_ff} + {1'b0, second_ff};
   assign full_now = (used >= {1'b0, cap});

   always_comb begin
      cap_in    = cap_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ovf1_in   = ovf1_ff;
      udf_in    = udf_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      widx      = first_ff;
      ridx      = first_ff;
      wdata     = req_data.value_first;
      priority if (cmd.cfg_wr) begin
         cap_in    = csr_data;
         first_in  = '0;
         second_in = '0;
      end else if (cmd.accept) begin
         ovf1_in = 1'b0;
         udf_in  = 1'b0;
         unique case (req_data.func)
            dssm_pkg::FUNC_PUSH: begin
               if (full_now) begin
                  ovf1_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  widx     = first_ff;
                  first_in = first_ff + 1'b1;
               end
            end
            dssm_pkg::FUNC_POP_FIRST: begin
               if (first_ff == '0) begin
                  udf_in = 1'b1;
               end else begin
                  mem_re   = 1'b1;
                  ridx     = first_ff - 1'b1;
                  first_in = first_ff - 1'b1;
               end
            end
            dssm_pkg::FUNC_POP_SECOND: begin
               if (second_ff == '0) begin
                  udf_in = 1'b1;
               end else begin
                  mem_re    = 1'b1;
                  ridx      = cap - second_ff;
                  second_in = second_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.finish) begin
         if (op_ff == dssm_pkg::FUNC_PUSH && !full_now) begin
            mem_we    = 1'b1;
            widx      = cap - 1'b1 - second_ff;
            wdata     = vs_ff;
            second_in = second_ff + 1'b1;
         end
      end
   end

   assign widx_ext = IW'(widx);
   assign ridx_ext = IW'(ridx);
   assign waddr    = widx_ext[AW-1:0];
   assign raddr    = ridx_ext[AW-1:0];

   // result of step two, flags taken from the counts after the item
   assign used_next = {1'b0, first_in} + {1'b0, second_in};
   assign is_pop    = (op_ff == dssm_pkg::FUNC_POP_FIRST) ||
                      (op_ff == dssm_pkg::FUNC_POP_SECOND);

   always_comb begin
      rsp_in.overflow_first  = ovf1_ff;
      rsp_in.overflow_second = (op_ff == dssm_pkg::FUNC_PUSH) && full_now;
      rsp_in.underflow       = udf_ff;
      rsp_in.first_empty     = (first_in == '0);
      rsp_in.second_empty    = (second_in == '0);
      rsp_in.is_full         = (used_next >= {1'b0, cap});
      priority if (udf_ff) begin
         rsp_in.pop_data = dssm_pkg::POP_UNDERFLOW;
      end else if (is_pop) begin
         rsp_in.pop_data = rd_ff;
      end else begin
         rsp_in.pop_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= dssm_pkg::CAP_RESET;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         cap_ff    <= cap_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf1_ff <= ovf1_in;
      udf_ff  <= udf_in;
      if (cmd.accept) begin
         op_ff <= req_data.func;
         vs_ff <= req_data.value_second;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[raddr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/dual_stack_shared_memory_top.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_top
// Two LIFO stacks sharing one slot memory, growing toward each other.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the item is taken at a
//   rising edge with start high and busy low. func selects push pair, pop
//   of the first stack or pop of the second stack.
//   Result channel: rsp_data is valid for exactly one cycle while rsp_strobe
//   is high. The receiver cannot stall; it must take every result.
//   Config channel: csr_data carries the capacity (clamped to 2..DEPTH and
//   at most 31); it is written when csr_valid and csr_ready are high, and a
//   write empties both stacks. Write only while the block is idle.
// Timing:
//   An item runs through an accept step, for the first memory access (first
//   push write, or the pop read), and a finish step, for the second push write
//   or for the registered read data. The single write port of the slot memory
//   sets this split. rsp_strobe is registered from the finish step, and the
//   result is taken at the edge that ends the strobe. busy is high for one cycle
//   after each accept, so no new item is taken while the last one finishes.
// Reset:
//   Synchronous, active high. Both stacks are emptied and the capacity
//   returns to 16. The slot memory is not cleared; only pushed slots are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dual_stack_shared_memory_top #(
   parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  dssm_pkg::req_type          req_data,
   // result channel
   output logic                       rsp_strobe,
   output dssm_pkg::rsp_type          rsp_data,
   // configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dssm_pkg::CAP_W-1:0] csr_data
);

   dssm_pkg::cmd_type cmd;

   // sequence each item through accept and finish
   dssm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // hold the stacks, the slot memory and the result register
   dssm_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

   // an accepted item raises busy, blocking the next one
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // every accepted item yields its result strobe after its finish step
   `ASSERT_AT(a_accept_result, clock, reset, start && !busy |-> ##2 rsp_strobe)

   // results never come in adjacent cycles
   `ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)

   // an underflow always reports all ones as data and no overflow on the first stack
   `ASSERT_AT(a_underflow_data, clock, reset, rsp_strobe && rsp_data.underflow |-> (rsp_data.pop_data == dssm_pkg::POP_UNDERFLOW) && !rsp_data.overflow_first)

endmodule

// ===== tb/sv/tb_dual_stack_shared_memory_top.sv =====
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_memory_top
// Self-checking bench for the two-stacks-in-one-array block. A short scripted
// opening drives empty pops, extreme values, the unused operation, one-slot
// and no-slot pushes and every capacity extreme. Then about 700 random items
// follow in bursts that lean toward push, toward pop or neither, so both
// stacks fill, empty and collide. Each item is run through a local model of
// both stacks, and every strobed result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_stack_shared_memory_top;

   import dssm_pkg::*;

   // func code that the package leaves unnamed; the block must treat it as a no-op
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam rsp_type UNDERFLOW_RSP =
      '{POP_UNDERFLOW, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

   typedef enum bit {ROW_ITEM, ROW_CAPACITY} row_kind_e;

   // one line of the opening script: either an item or a capacity write;
   // typed rows carry a hand-written result, the rest use the model
   typedef struct {
      row_kind_e        kind;
      logic [CAP_W-1:0] capacity;
      req_type          item;
      bit               typed;
      rsp_type          result;
   } script_row_t;

   // ---------------------------------------------------------------------------
   // Block pins; every input holds a known value from time zero
   // ---------------------------------------------------------------------------
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             busy;
   req_type          req_data   = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data   = '0;

   // ---------------------------------------------------------------------------
   // Local copy of both stacks and the capacity register
   // ---------------------------------------------------------------------------
   logic [DATA_W-1:0] slot_mirror [DEPTH_DEFAULT];
   int unsigned       lower_depth = 0;      // first stack, grows from slot 0
   int unsigned       upper_depth = 0;      // second stack, grows from the top
   logic [CAP_W-1:0]  cap_mirror  = CAP_RESET;

   rsp_type stack_results_due [$];
   int      fail_count      = 0;
   int      sender_idle_pct = 31;

   logic [CAP_W-1:0] phase_caps [6] = '{5'd3, 5'd17, 5'd0, 5'd31, 5'd2, 5'd9};

   script_row_t opening_script [30] = '{
      // empty stacks straight out of reset, capacity 16
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b1, UNDERFLOW_RSP},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b1, UNDERFLOW_RSP},
      '{ROW_ITEM, 5'd0, '{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      // largest and smallest values, then back out again
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b1,
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b1,
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      // smallest capacity: one pair fills it, the next pair is dropped
      '{ROW_CAPACITY, 5'd2, '0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'hFFFF_FFFF, 32'h0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, 5'd0, '{FUNC_UNUSED, 32'h0, 32'h0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      // one free slot: the first value lands, the second is dropped
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1,
        '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      // a stored all-ones value must not look like an underflow
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b1, UNDERFLOW_RSP},
      // capacity below the floor acts as two
      '{ROW_CAPACITY, 5'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h0000_0001, 32'hFFFF_FFFE}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      // capacity above the memory size acts as the memory size
      '{ROW_CAPACITY, 5'd31, '0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h0000_0001, 32'hFFFF_FFFE}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      // odd capacity: second pair overflows on its second half only
      '{ROW_CAPACITY, 5'd3, '0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_PUSH, 32'h0F0F_0F0F, 32'hF0F0_F0F0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_FIRST, 32'h0, 32'h0}, 1'b0, '0},
      '{ROW_ITEM, 5'd0, '{FUNC_POP_SECOND, 32'h0, 32'h0}, 1'b0, '0}
   };

   dual_stack_shared_memory_top #(
      .DEPTH (DEPTH_DEFAULT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #2_000_000;
      $display("dual_stack_shared_memory_top: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stack model
   // ---------------------------------------------------------------------------

   // Clamp the capacity register into the range the memory supports.
   function automatic int unsigned live_capacity();
      if (cap_mirror < CAP_MIN) return CAP_MIN;
      if (cap_mirror > DEPTH_DEFAULT) return DEPTH_DEFAULT;
      return cap_mirror;
   endfunction

   function automatic bit stacks_full();
      return lower_depth + upper_depth >= live_capacity();
   endfunction

   // Apply one item to the local stacks and return the result it must produce.
   function automatic rsp_type predict_stacks(input req_type item);
      rsp_type     r;
      int unsigned cap;
      cap = live_capacity();
      r   = '0;
      case (item.func)
         FUNC_PUSH: begin
            // the first value gets the last free slot if only one is left
            if (!stacks_full()) begin
               slot_mirror[lower_depth] = item.value_first;
               lower_depth++;
            end else begin
               r.overflow_first = 1'b1;
            end
            if (!stacks_full()) begin
               slot_mirror[cap - 1 - upper_depth] = item.value_second;
               upper_depth++;
            end else begin
               r.overflow_second = 1'b1;
            end
         end
         FUNC_POP_FIRST: begin
            if (lower_depth == 0) begin
               r.pop_data  = POP_UNDERFLOW;
               r.underflow = 1'b1;
            end else begin
               lower_depth--;
               r.pop_data = slot_mirror[lower_depth];
            end
         end
         FUNC_POP_SECOND: begin
            if (upper_depth == 0) begin
               r.pop_data  = POP_UNDERFLOW;
               r.underflow = 1'b1;
            end else begin
               r.pop_data = slot_mirror[cap - upper_depth];
               upper_depth--;
            end
         end
         default: begin
            // unused code: state untouched, only status reported
         end
      endcase
      r.first_empty  = (lower_depth == 0);
      r.second_empty = (upper_depth == 0);
      r.is_full      = stacks_full();
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Random words half the time, else one of the extremes, all-ones or zero.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '1;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Drop start and hold until every due result has arrived and busy is low.
   // Always advance at least one edge so start is not driven twice in a step.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (stack_results_due.size() != 0 || busy);
   endtask

   // Present one item, optionally after a random gap, and hold it until the
   // block takes it. Record the typed result if given, else the model's.
   task automatic issue_op(input req_type item, input bit typed,
                           input rsp_type written);
      rsp_type model;
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      model = predict_stacks(item);
      stack_results_due.push_back(typed ? written : model);
   endtask

   // Write capacity only with the block idle; the write also empties both stacks.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cap_mirror  = value;
      lower_depth = 0;
      upper_depth = 0;
   endtask

   task automatic compare_result(input rsp_type want, input rsp_type got);
      if (got.pop_data !== want.pop_data) begin
         $error("pop_data: expected %h, got %h", want.pop_data, got.pop_data);
         fail_count++;
      end
      if (got.overflow_first !== want.overflow_first) begin
         $error("overflow_first: expected %b, got %b",
                want.overflow_first, got.overflow_first);
         fail_count++;
      end
      if (got.overflow_second !== want.overflow_second) begin
         $error("overflow_second: expected %b, got %b",
                want.overflow_second, got.overflow_second);
         fail_count++;
      end
      if (got.underflow !== want.underflow) begin
         $error("underflow: expected %b, got %b", want.underflow, got.underflow);
         fail_count++;
      end
      if (got.first_empty !== want.first_empty) begin
         $error("first_empty: expected %b, got %b", want.first_empty, got.first_empty);
         fail_count++;
      end
      if (got.second_empty !== want.second_empty) begin
         $error("second_empty: expected %b, got %b",
                want.second_empty, got.second_empty);
         fail_count++;
      end
      if (got.is_full !== want.is_full) begin
         $error("is_full: expected %b, got %b", want.is_full, got.is_full);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checker: sample on the edge that ends the strobe cycle
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (stack_results_due.size() == 0) begin
            $error("rsp_strobe with no result due, rsp_data %h", rsp_data);
            fail_count++;
         end else begin
            compare_result(stack_results_due.pop_front(), rsp_data);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_type item;
      int      push_bias;
      int      burst_left;
      int      roll;
      push_bias  = 50;
      burst_left = 0;

      // Hold reset, then release it on an edge.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the opening script at the light sender gap setting.
      foreach (opening_script[i]) begin
         if (opening_script[i].kind == ROW_CAPACITY) begin
            write_capacity(opening_script[i].capacity);
         end else begin
            issue_op(opening_script[i].item, opening_script[i].typed,
                     opening_script[i].result);
         end
      end

      // Random part: six capacity phases, two per sender gap setting.
      // Bursts lean toward push, toward pop or neither, so the stacks both fill up
      // and run dry, whatever the capacity.
      phase_caps[5] = 5'($urandom_range(31));
      for (int phase = 0; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 80 : 0;
         write_capacity(phase_caps[phase]);
         for (int n = 0; n < 115; n++) begin
            if (burst_left == 0) begin
               case ($urandom_range(2))
                  0:       push_bias = 15;
                  1:       push_bias = 50;
                  default: push_bias = 85;
               endcase
               burst_left = $urandom_range(40, 12);
            end
            burst_left--;

            roll = $urandom_range(99);
            if (roll < 3) begin
               item.func = FUNC_UNUSED;
            end else if (roll < push_bias) begin
               item.func = FUNC_PUSH;
            end else begin
               item.func = $urandom_range(1) ? FUNC_POP_FIRST : FUNC_POP_SECOND;
            end
            item.value_first  = pick_value();
            item.value_second = pick_value();

            // Now and then, stop feeding until the block has answered everything.
            if (n == 57 || $urandom_range(199) == 0) begin
               wait_drained();
            end
            issue_op(item, 1'b0, '0);
         end
      end

      // Drain, then wait for any stray strobe to show up.
      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("dual_stack_shared_memory_top: match");
      end else begin
         $display("dual_stack_shared_memory_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== dual_stack_shared_memory_top.f =====
+incdir+rtl
rtl/dssm_pkg.sv
rtl/dssm_ctrl.sv
rtl/dssm_datapath.sv
rtl/dual_stack_shared_memory_top.sv
tb/sv/tb_dual_stack_shared_memory_top.sv
